// File: hw/rtl/tbplc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbplc_pkg
// Shared types, constants and the event encoder for the two-button
// press / release / long-press classifier.
// ----------------------------------------------------------------------------
package tbplc_pkg;

  typedef logic [1:0]  mask_t;
  typedef logic [3:0]  event_t;
  typedef logic [7:0]  deb_t;
  typedef logic [15:0] hold_t;
  typedef logic        cfg_idx_t;
  typedef logic [15:0] cfg_data_t;

  // register indexes on the config port
  localparam cfg_idx_t CFG_DEBOUNCE_TICKS   = 1'b0;
  localparam cfg_idx_t CFG_LONG_PRESS_TICKS = 1'b1;

  localparam deb_t  DEBOUNCE_RESET = 8'd5;
  localparam hold_t LONG_RESET     = 16'd200;
  localparam hold_t HOLD_MAX       = 16'hFFFF;

  localparam mask_t MASK_NONE  = 2'b00;
  localparam mask_t MASK_RIGHT = 2'b10;
  localparam mask_t MASK_BOTH  = 2'b11;

  // event code bases: code = base + {1 left, 2 right, 3 both}
  localparam event_t EV_NONE         = 4'd0;
  localparam event_t EV_PRESS_BASE   = 4'd0;
  localparam event_t EV_RELEASE_BASE = 4'd3;
  localparam event_t EV_LONG_BASE    = 4'd6;
  localparam event_t EV_MAX          = 4'd9;

  typedef struct packed {
    logic      valid;
    cfg_idx_t  index;
    cfg_data_t data;
  } cfg_wr_t;

  // both wins over right, right over left
  function automatic event_t mask_code(input mask_t mask, input event_t base);
    event_t k;
    if ((mask & MASK_BOTH) == MASK_BOTH) begin
      k = 4'd3;
    end else if ((mask & MASK_RIGHT) != MASK_NONE) begin
      k = 4'd2;
    end else begin
      k = 4'd1;
    end
    return base + k;
  endfunction

endpackage

// File: hw/rtl/tbplc_sample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbplc_sample
// Input register: captures the active-low pin levels as a pressed mask and
// holds it until the classifier stage can move it on.
// ----------------------------------------------------------------------------
module tbplc_sample (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_left_level,
  input  logic              in_right_level,
  input  logic              out_busy,
  output logic              s1_adv,
  output tbplc_pkg::mask_t  s1_mask
);

  logic             s1_valid_r, s1_valid_nxt;
  tbplc_pkg::mask_t s1_mask_r;
  logic             accept;

  assign s1_adv   = s1_valid_r & ~out_busy;
  assign in_stall = s1_valid_r & out_busy;
  assign accept   = in_valid & ~in_stall;

  assign s1_valid_nxt = accept | (s1_valid_r & ~s1_adv);
  assign s1_mask      = s1_mask_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // pin low means pressed: bit 0 left, bit 1 right
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mask_r <= {~in_right_level, ~in_left_level};
    end
  end

endmodule

// File: hw/rtl/tbplc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbplc_core
// Config registers, debounce filter and press/release/long-press state.
// Updates state and produces one event code per advanced sample.
// ----------------------------------------------------------------------------
module tbplc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  tbplc_pkg::cfg_wr_t  cfg_wr,
  input  logic                adv,
  input  tbplc_pkg::mask_t    raw,
  output tbplc_pkg::event_t   code
);

  tbplc_pkg::deb_t  debounce_ticks_r, debounce_ticks_nxt;
  tbplc_pkg::hold_t long_press_ticks_r, long_press_ticks_nxt;

  tbplc_pkg::mask_t filt_r, filt_nxt;
  tbplc_pkg::mask_t prev_r, prev_nxt;
  tbplc_pkg::deb_t  fcnt_r, fcnt_nxt;
  logic             was_pressed_r, was_pressed_nxt;
  logic             was_released_r, was_released_nxt;
  tbplc_pkg::hold_t hold_r, hold_nxt;
  logic             long_r, long_nxt;

  tbplc_pkg::deb_t  fcnt_inc;
  tbplc_pkg::hold_t hold_inc;

  // config decode
  always_comb begin
    debounce_ticks_nxt   = debounce_ticks_r;
    long_press_ticks_nxt = long_press_ticks_r;
    if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        tbplc_pkg::CFG_DEBOUNCE_TICKS:   debounce_ticks_nxt   = cfg_wr.data[7:0];
        tbplc_pkg::CFG_LONG_PRESS_TICKS: long_press_ticks_nxt = cfg_wr.data;
        default: ;
      endcase
    end
  end

  assign fcnt_inc = fcnt_r + 8'd1;
  assign hold_inc = (hold_r < tbplc_pkg::HOLD_MAX) ? hold_r + 16'd1 : hold_r;

  always_comb begin
    filt_nxt         = filt_r;
    fcnt_nxt         = fcnt_r;
    prev_nxt         = prev_r;
    was_pressed_nxt  = was_pressed_r;
    was_released_nxt = was_released_r;
    hold_nxt         = hold_r;
    long_nxt         = long_r;
    code             = tbplc_pkg::EV_NONE;

    // debounce: zero threshold behaves as one since fcnt_inc >= 0
    if (raw != filt_r) begin
      if (fcnt_inc >= debounce_ticks_r) begin
        filt_nxt = raw;
        fcnt_nxt = '0;
      end else begin
        fcnt_nxt = fcnt_inc;
      end
    end else begin
      fcnt_nxt = '0;
    end

    if (filt_nxt != prev_r) begin
      if (filt_nxt == tbplc_pkg::MASK_NONE) begin
        if (was_pressed_r) begin
          if (!long_r && prev_r != tbplc_pkg::MASK_NONE) begin
            code = tbplc_pkg::mask_code(prev_r, tbplc_pkg::EV_RELEASE_BASE);
          end
          long_nxt = 1'b0;
        end
        was_pressed_nxt = 1'b0;
      end else begin
        was_pressed_nxt = 1'b1;
        if (was_released_r) begin
          code = tbplc_pkg::mask_code(filt_nxt, tbplc_pkg::EV_PRESS_BASE);
        end
        was_released_nxt = 1'b0;
      end
      prev_nxt = filt_nxt;
    end else if (filt_nxt != tbplc_pkg::MASK_NONE) begin
      // hold count keeps running across changes between pressed patterns
      hold_nxt = hold_inc;
      if (hold_inc == long_press_ticks_r) begin
        long_nxt = 1'b1;
        code     = tbplc_pkg::mask_code(filt_nxt, tbplc_pkg::EV_LONG_BASE);
      end
    end else begin
      hold_nxt         = '0;
      was_released_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= tbplc_pkg::DEBOUNCE_RESET;
      long_press_ticks_r <= tbplc_pkg::LONG_RESET;
      filt_r             <= tbplc_pkg::MASK_NONE;
      prev_r             <= tbplc_pkg::MASK_NONE;
      fcnt_r             <= '0;
      was_pressed_r      <= 1'b0;
      was_released_r     <= 1'b0;
      hold_r             <= '0;
      long_r             <= 1'b0;
    end else begin
      debounce_ticks_r   <= debounce_ticks_nxt;
      long_press_ticks_r <= long_press_ticks_nxt;
      if (adv) begin
        filt_r         <= filt_nxt;
        prev_r         <= prev_nxt;
        fcnt_r         <= fcnt_nxt;
        was_pressed_r  <= was_pressed_nxt;
        was_released_r <= was_released_nxt;
        hold_r         <= hold_nxt;
        long_r         <= long_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/tbplc_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbplc_out
// Result register: holds one event code until the consumer takes it.
// ----------------------------------------------------------------------------
module tbplc_out (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  tbplc_pkg::event_t  code,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output tbplc_pkg::event_t  out_event_code
);

  logic              valid_r, valid_nxt;
  tbplc_pkg::event_t code_r;

  // full and not draining this cycle
  assign busy      = valid_r & out_stall;
  assign valid_nxt = load | busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_r <= code;
    end
  end

  assign out_valid      = valid_r;
  assign out_event_code = code_r;

endmodule

// File: hw/rtl/two_button_press_release_long_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_button_press_release_long_classifier
// Debounces two active-low buttons and reports press, release and
// long-press events, one event code per pin sample.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_stall    in_left_level, in_right_level
//   out_     out  out_valid/out_stall  out_event_code (0 none, 1-9 events)
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One sample per cycle unless stalled; input register, then result register.
// Classification is one pass of compares and counters between the two.
// Synchronous active-low reset clears state and loads config defaults.
// A stalled result holds the pipe; the input register still takes a sample
// while the result register drains. cfg_ready is always high.
// ----------------------------------------------------------------------------
module two_button_press_release_long_classifier (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_left_level,
  input  logic                   in_right_level,
  output logic                   out_valid,
  input  logic                   out_stall,
  output tbplc_pkg::event_t      out_event_code,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  tbplc_pkg::cfg_idx_t    cfg_index,
  input  tbplc_pkg::cfg_data_t   cfg_data
);

  logic               out_busy;
  logic               s1_adv;
  tbplc_pkg::mask_t   s1_mask;
  tbplc_pkg::event_t  code;
  tbplc_pkg::cfg_wr_t cfg_wr;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid & cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  tbplc_sample u_sample (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_level  (in_left_level),
    .in_right_level (in_right_level),
    .out_busy       (out_busy),
    .s1_adv         (s1_adv),
    .s1_mask        (s1_mask)
  );

  tbplc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .adv    (s1_adv),
    .raw    (s1_mask),
    .code   (code)
  );

  tbplc_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (s1_adv),
    .code           (code),
    .busy           (out_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_code (out_event_code)
  );

endmodule

// File: hw/rtl/tbplc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbplc_checker
// Port-level checks for the classifier, bound to the top level.
// ----------------------------------------------------------------------------
module tbplc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tbplc_pkg::event_t  out_event_code,
  input logic               cfg_ready
);

  // a held result keeps its code
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_code))
    else $error("result changed while stalled");

  // input only backs up when the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_code <= tbplc_pkg::EV_MAX)
    else $error("event code out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipe not empty after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> cfg_ready)
    else $error("config port not ready");

endmodule

bind two_button_press_release_long_classifier tbplc_checker u_tbplc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_event_code (out_event_code),
  .cfg_ready      (cfg_ready)
);
